// File: design/gcs_pkg.sv
// Shared types and constants for the grayscale contrast stretch block.
package gcs_pkg;

    localparam int unsigned PIX_W      = 8;
    localparam int unsigned DIV_STEPS  = PIX_W;
    localparam int unsigned CNT_W      = $clog2(DIV_STEPS);
    localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;
    localparam logic [PIX_W-1:0] ZERO_LEVEL = 8'd0;

    localparam logic KIND_MEASURE = 1'b0;
    localparam logic KIND_MAP     = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic take;      // input beat accepted this cycle
        logic step;      // one quotient bit of the divider
        logic load_out;  // move the finished pixel into the output register
    } gcs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic special_now;  // map pixel at the input needs no division
        logic out_busy;     // output register holds a beat that is not taken now
    } gcs_status_t;

endpackage

// File: design/gcs_in_if.sv
// Input pixel channel: valid/ready handshake with kind, first and pixel.
interface gcs_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic       first;
    logic [7:0] pixel;

    modport source (output valid, output kind, output first, output pixel, input ready);
    modport sink   (input valid, input kind, input first, input pixel, output ready);
endinterface

// File: design/gcs_out_if.sv
// Output pixel channel: valid/ready handshake with the stretched level.
interface gcs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] stretched;

    modport source (output valid, output stretched, input ready);
    modport sink   (input valid, input stretched, output ready);
endinterface

// File: design/gcs_ctrl.sv
// Controller state machine: sequences accept, division steps and output load.
module gcs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_kind,
    input  gcs_pkg::gcs_status_t status,
    output logic                in_ready,
    output gcs_pkg::gcs_cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [gcs_pkg::CNT_W-1:0] cnt_reg;
    logic [gcs_pkg::CNT_W-1:0] cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        in_ready     = 1'b0;
        cmd.take     = 1'b0;
        cmd.step     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (in_kind == gcs_pkg::KIND_MAP)
                    begin
                        cnt_next   = '0;
                        state_next = status.special_now ? ST_LOAD : ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == gcs_pkg::CNT_W'(gcs_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: design/gcs_dp.sv
// Datapath: min/max trackers, scaled numerator, restoring divider, output register.
module gcs_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  gcs_pkg::gcs_cmd_t   cmd,
    input  logic                in_kind,
    input  logic                in_first,
    input  logic [7:0]          in_pixel,
    input  logic                out_ready,
    output gcs_pkg::gcs_status_t status,
    output logic                out_valid,
    output logic [7:0]          stretched
);

    logic [7:0]  low_reg;
    logic [7:0]  low_next;
    logic [7:0]  high_reg;
    logic [7:0]  high_next;
    logic [7:0]  span_reg;
    logic [7:0]  rem_reg;
    logic [7:0]  quo_reg;
    logic        spec_reg;
    logic [7:0]  spec_val_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  stretched_reg;

    logic [7:0]  diff;
    logic [15:0] num;
    logic        special_now;
    logic [7:0]  spec_val;
    logic [9:0]  trial;
    logic        trial_ge;

    // (p - low) * 255 as (d << 8) - d
    assign diff = in_pixel - low_reg;
    assign num  = {diff, 8'd0} - {8'd0, diff};

    assign special_now = (high_reg <= low_reg) || (in_pixel <= low_reg)
                         || (in_pixel >= high_reg);
    assign spec_val    = ((high_reg > low_reg) && (in_pixel >= high_reg))
                         ? gcs_pkg::FULL_SCALE : gcs_pkg::ZERO_LEVEL;

    // one restoring step; top byte of num is already below the span
    assign trial    = {1'b0, rem_reg, quo_reg[7]} - {2'b00, span_reg};
    assign trial_ge = !trial[9];

    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        if (cmd.take && (in_kind == gcs_pkg::KIND_MEASURE))
        begin
            if (in_first)
            begin
                low_next  = in_pixel;
                high_next = in_pixel;
            end
            else
            begin
                if (in_pixel < low_reg)
                begin
                    low_next = in_pixel;
                end
                if (in_pixel > high_reg)
                begin
                    high_next = in_pixel;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg       <= gcs_pkg::FULL_SCALE;
            high_reg      <= gcs_pkg::ZERO_LEVEL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            low_reg       <= low_next;
            high_reg      <= high_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && (in_kind == gcs_pkg::KIND_MAP))
        begin
            span_reg     <= high_reg - low_reg;
            rem_reg      <= num[15:8];
            quo_reg      <= num[7:0];
            spec_reg     <= special_now;
            spec_val_reg <= spec_val;
        end
        else if (cmd.step)
        begin
            rem_reg <= trial_ge ? trial[7:0] : {rem_reg[6:0], quo_reg[7]};
            quo_reg <= {quo_reg[6:0], trial_ge};
        end
        if (cmd.load_out)
        begin
            stretched_reg <= spec_reg ? spec_val_reg : quo_reg;
        end
    end

    assign status.special_now = special_now;
    assign status.out_busy    = out_valid_reg && !out_ready;
    assign out_valid          = out_valid_reg;
    assign stretched          = stretched_reg;

endmodule

// File: design/grayscale_contrast_stretch.sv
// Top level of the grayscale min/max contrast stretch block.
//
// Usage: a frame is streamed twice on pixin. Measure beats (kind 0) update the
// running minimum and maximum; a beat with first set restarts both at that
// pixel. Measure beats give no output beat. Map beats (kind 1) each give one
// beat on pixout: (pixel - min) * 255 / (max - min), truncated, 0 at or below
// min, 255 at or above max, and 0 when max is not above min.
// Timing: after a measure beat the block stays ready; after a map beat it is
// not ready again until its load. A map beat that needs division runs
// through the bit-serial restoring divider (one quotient bit per cycle), then
// the load step that loads the output register; one that saturates or hits a
// flat frame skips the divider. Result is valid on pixout the cycle after load.
// Reset: min tracker to 255, max tracker to 0, no output beat pending.
// Stall: the output register holds its beat while pixout.ready is low; the
// block keeps accepting measure beats and can divide the next map pixel,
// then waits in the load step until the register frees.
module grayscale_contrast_stretch (
    input  logic       clk,
    input  logic       rst_n,
    gcs_in_if.sink     pixin,
    gcs_out_if.source  pixout
);

    gcs_pkg::gcs_cmd_t    cmd;
    gcs_pkg::gcs_status_t status;

    gcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixin.valid),
        .in_kind  (pixin.kind),
        .status   (status),
        .in_ready (pixin.ready),
        .cmd      (cmd)
    );

    gcs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_kind   (pixin.kind),
        .in_first  (pixin.first),
        .in_pixel  (pixin.pixel),
        .out_ready (pixout.ready),
        .status    (status),
        .out_valid (pixout.valid),
        .stretched (pixout.stretched)
    );

    // a measure beat never produces an output beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixin.valid && pixin.ready && (pixin.kind == gcs_pkg::KIND_MEASURE)
         && !pixout.valid) |=> !pixout.valid)
        else $error("output beat after a measure beat");

    // after a map beat is accepted, the input is not ready in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixin.valid && pixin.ready && (pixin.kind == gcs_pkg::KIND_MAP))
        |=> !pixin.ready)
        else $error("input accepted right after a map beat");

    // output register is never overwritten while its beat waits
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !status.out_busy)
        else $error("output register loaded while stalled");

    // divider steps never overlap an input accept
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !cmd.take && !pixin.ready)
        else $error("divider step during input accept");

endmodule

// File: tb/grayscale_contrast_stretch_test.sv
// Self-checking testbench for grayscale_contrast_stretch: directed and random frames.
module grayscale_contrast_stretch_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 3000;
    localparam int END_CYCLES  = 20;

    // Tracks min/max like the block and queues the levels the map beats must give.
    class contrast_model;
        logic [gcs_pkg::PIX_W-1:0] low_q;
        logic [gcs_pkg::PIX_W-1:0] high_q;
        logic [gcs_pkg::PIX_W-1:0] pending_levels[$];
        int                        mismatches;

        function new();
            low_q      = gcs_pkg::FULL_SCALE;
            high_q     = gcs_pkg::ZERO_LEVEL;
            mismatches = 0;
        endfunction

        function logic [gcs_pkg::PIX_W-1:0] stretch_level(logic [gcs_pkg::PIX_W-1:0] p);
            int unsigned span;
            int unsigned scaled;
            if (high_q <= low_q)
                return gcs_pkg::ZERO_LEVEL;
            if (p <= low_q)
                return gcs_pkg::ZERO_LEVEL;
            if (p >= high_q)
                return gcs_pkg::FULL_SCALE;
            span   = int'(high_q) - int'(low_q);
            scaled = (int'(p) - int'(low_q)) * int'(gcs_pkg::FULL_SCALE);
            return gcs_pkg::PIX_W'(scaled / span);
        endfunction

        function void take_pixel(logic k, logic f, logic [gcs_pkg::PIX_W-1:0] p);
            if (k == gcs_pkg::KIND_MEASURE)
            begin
                if (f)
                begin
                    low_q  = p;
                    high_q = p;
                end
                else
                begin
                    if (p < low_q)
                        low_q = p;
                    if (p > high_q)
                        high_q = p;
                end
            end
            else
            begin
                pending_levels.push_back(stretch_level(p));
            end
        endfunction

        function void match_level(logic [gcs_pkg::PIX_W-1:0] got);
            logic [gcs_pkg::PIX_W-1:0] want;
            if (pending_levels.size() == 0)
            begin
                $error("stretched: no beat expected, got %0d", got);
                mismatches++;
                return;
            end
            want = pending_levels.pop_front();
            if (got !== want)
            begin
                $error("stretched: expected %0d, got %0d", want, got);
                mismatches++;
            end
        endfunction

        function void close_out();
            if (pending_levels.size() != 0)
            begin
                $error("stretched: %0d beats never arrived", pending_levels.size());
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    gcs_in_if  pixin();
    gcs_out_if pixout();

    grayscale_contrast_stretch dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixin  (pixin),
        .pixout (pixout)
    );

    contrast_model contrast = new();

    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int sent_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Output side: check each beat, then pick ready for the next cycle.
    initial
    begin
        int hold_left;
        hold_left = 0;
        pixout.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pixout.valid && pixout.ready)
                contrast.match_level(pixout.stretched);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pixout.ready <= 1'b0;
            end
            else
            begin
                pixout.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: cycles without any beat on either side.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((pixin.valid && pixin.ready) || (pixout.valid && pixout.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Called at the edge of the previous beat (or any edge); returns at the accepting edge.
    task automatic send_pixel(input logic k, input logic f,
                              input logic [gcs_pkg::PIX_W-1:0] p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixin.valid <= 1'b0;
            @(posedge clk);
        end
        pixin.valid <= 1'b1;
        pixin.kind  <= k;
        pixin.first <= f;
        pixin.pixel <= p;
        @(posedge clk);
        while (!pixin.ready)
            @(posedge clk);
        contrast.take_pixel(k, f, p);
        sent_count++;
    endtask

    task automatic wait_for_levels();
        pixin.valid <= 1'b0;
        do
            @(posedge clk);
        while (contrast.pending_levels.size() != 0);
    endtask

    // Mostly measure-then-map frames with random content, some stray beats.
    task automatic run_frames(input int budget);
        logic [gcs_pkg::PIX_W-1:0] frame[16];
        int n;
        int lo;
        int spread;
        int mode;
        int stop;
        stop = sent_count + budget;
        while (sent_count < stop)
        begin
            mode = $urandom_range(99);
            if (mode < 15)
            begin
                send_pixel(1'($urandom_range(1)), 1'($urandom_range(1)),
                           gcs_pkg::PIX_W'($urandom_range(255)));
            end
            else
            begin
                n = (mode < 20) ? 16 : $urandom_range(1, 6);
                case ($urandom_range(3))
                    0:       spread = 0;
                    1:       spread = $urandom_range(1, 8);
                    2:       spread = $urandom_range(9, 80);
                    default: spread = 255;
                endcase
                lo = $urandom_range(255 - spread);
                for (int i = 0; i < n; i++)
                    frame[i] = gcs_pkg::PIX_W'(lo + $urandom_range(spread));
                // occasionally keep tracking across frames
                for (int i = 0; i < n; i++)
                    send_pixel(gcs_pkg::KIND_MEASURE, (i == 0) && ($urandom_range(7) != 0),
                               frame[i]);
                for (int i = 0; i < n; i++)
                begin
                    send_pixel(gcs_pkg::KIND_MAP, 1'($urandom_range(1)), frame[i]);
                    if ($urandom_range(4) == 0)
                        send_pixel(gcs_pkg::KIND_MAP, 1'b0,
                                   gcs_pkg::PIX_W'($urandom_range(255)));
                end
            end
        end
    endtask

    initial
    begin
        pixin.valid    <= 1'b0;
        pixin.kind     <= gcs_pkg::KIND_MEASURE;
        pixin.first    <= 1'b0;
        pixin.pixel    <= gcs_pkg::ZERO_LEVEL;
        rst_n          <= 1'b0;
        send_idle_pct  = 6;
        recv_stall_pct = 54;
        hold_request   = 0;
        sent_count     = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing measured yet: trackers crossed
        send_pixel(gcs_pkg::KIND_MAP, 1'b0, 8'd128);
        send_pixel(gcs_pkg::KIND_MAP, 1'b1, 8'd0);
        // untagged measure beat after reset sets both trackers -> flat
        send_pixel(gcs_pkg::KIND_MEASURE, 1'b0, 8'd100);
        send_pixel(gcs_pkg::KIND_MAP, 1'b0, 8'd100);
        send_pixel(gcs_pkg::KIND_MEASURE, 1'b0, 8'd50);
        send_pixel(gcs_pkg::KIND_MEASURE, 1'b0, 8'd200);
        send_pixel(gcs_pkg::KIND_MAP, 1'b0, 8'd0);
        send_pixel(gcs_pkg::KIND_MAP, 1'b0, 8'd50);
        send_pixel(gcs_pkg::KIND_MAP, 1'b0, 8'd51);
        send_pixel(gcs_pkg::KIND_MAP, 1'b1, 8'd125);
        send_pixel(gcs_pkg::KIND_MAP, 1'b0, 8'd199);
        send_pixel(gcs_pkg::KIND_MAP, 1'b0, 8'd200);
        send_pixel(gcs_pkg::KIND_MAP, 1'b0, 8'd255);
        // full range
        send_pixel(gcs_pkg::KIND_MEASURE, 1'b1, 8'd0);
        send_pixel(gcs_pkg::KIND_MEASURE, 1'b0, 8'd255);
        send_pixel(gcs_pkg::KIND_MAP, 1'b0, 8'd1);
        send_pixel(gcs_pkg::KIND_MAP, 1'b0, 8'd128);
        send_pixel(gcs_pkg::KIND_MAP, 1'b0, 8'd254);
        // flat frame at white
        send_pixel(gcs_pkg::KIND_MEASURE, 1'b1, 8'd255);
        send_pixel(gcs_pkg::KIND_MEASURE, 1'b0, 8'd255);
        send_pixel(gcs_pkg::KIND_MAP, 1'b0, 8'd255);
        send_pixel(gcs_pkg::KIND_MAP, 1'b0, 8'd0);

        run_frames(210);
        wait_for_levels();

        send_idle_pct  = 54;
        recv_stall_pct = 6;
        run_frames(230);

        // no idling; a long output stall backs up the input side
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 200;
        run_frames(240);

        pixin.valid <= 1'b0;
        while (contrast.pending_levels.size() != 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);
        contrast.close_out();

        if (contrast.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
design/gcs_pkg.sv
design/gcs_in_if.sv
design/gcs_out_if.sv
design/gcs_ctrl.sv
design/gcs_dp.sv
design/grayscale_contrast_stretch.sv
tb/grayscale_contrast_stretch_test.sv
